/* rtl/short_descriptor_table_walker_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the short-descriptor table walker
// Concurrent assertion wrappers that are clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SHORT_DESCRIPTOR_TABLE_WALKER_CORE_MACROS_SVH
`define SHORT_DESCRIPTOR_TABLE_WALKER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SDTW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdtw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SDTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdtw assertion failed");

`else

`define SDTW_ASSERT_SAME(label, ante, cons)
`define SDTW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/sdtw_pkg.sv */
// ----------------------------------------------------------------------------
// Short-descriptor table walker package
// Shared item types, operation codes and field constants.
// ----------------------------------------------------------------------------
package sdtw_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Input actions.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DESC  = 1'b1;

  // Result kinds.
  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Page kinds.
  localparam logic [1:0] PK_SECTION      = 2'd0;
  localparam logic [1:0] PK_SUPERSECTION = 2'd1;
  localparam logic [1:0] PK_LARGE        = 2'd2;
  localparam logic [1:0] PK_SMALL        = 2'd3;

  // Walk status.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_L1_FAULT = 3'd1;
  localparam logic [2:0] ST_L2_FAULT = 3'd2;
  localparam logic [2:0] ST_RESERVED = 3'd3;
  localparam logic [2:0] ST_ORDER    = 3'd4;

  // Descriptor type field, bits 1:0.
  localparam logic [1:0] DESC_FAULT    = 2'd0;
  localparam logic [1:0] DESC_TABLE    = 2'd1;
  localparam logic [1:0] DESC_SECTION  = 2'd2;
  localparam logic [1:0] DESC_RESERVED = 2'd3;

  // Level-2 descriptor type field.
  localparam logic [1:0] L2_FAULT = 2'd0;
  localparam logic [1:0] L2_LARGE = 2'd1;

  // Bit of a section descriptor that marks a supersection.
  localparam int unsigned SUPER_BIT = 18;

  // Configuration register indexes.
  localparam logic CFG_TTB0 = 1'b0;
  localparam logic CFG_TTB1 = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] virt_addr;
    logic        base_select;
    logic [31:0] read_word;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] read_address;
    logic [39:0] phys_addr;
    logic [1:0]  page_kind;
    logic [2:0]  status;
  } out_item_t;

  // Operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ORDER = 2'd1,
    OP_L1    = 2'd2,
    OP_L2    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] va;
    logic [31:0] word;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

endpackage

/* rtl/sdtw_if.sv */
// ----------------------------------------------------------------------------
// Short-descriptor table walker channels
// Valid/ready channels for walk items and walk results.
// ----------------------------------------------------------------------------
interface sdtw_in_if;
  import sdtw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sdtw_out_if;
  import sdtw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sdtw_front.sv */
// ----------------------------------------------------------------------------
// Walker front end
// Tracks the walk stage, classifies each transaction and queues an operation.
// ----------------------------------------------------------------------------
module sdtw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  sdtw_pkg::in_item_t in_item,
  input  logic [31:0]       ttb0,
  input  logic [31:0]       ttb1,
  output sdtw_pkg::q_port_t wr
);
  import sdtw_pkg::*;

  typedef enum logic [1:0] {
    STG_IDLE = 2'd0,
    STG_L1   = 2'd1,
    STG_L2   = 2'd2
  } stage_t;

  stage_t      stage;
  stage_t      stage_next;
  logic [31:0] held_va;
  logic [31:0] held_va_next;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    stage_next     = stage;
    held_va_next   = held_va;
    wr.valid       = accept;
    wr.entry.op    = OP_ORDER;
    wr.entry.va    = held_va;
    wr.entry.word  = in_item.read_word;
    if (in_item.action == ACT_START) begin
      if (stage == STG_L1 || stage == STG_L2) begin
        wr.entry.op = OP_ORDER;
      end else begin
        wr.entry.op   = OP_START;
        wr.entry.va   = in_item.virt_addr;
        wr.entry.word = in_item.base_select ? ttb1 : ttb0;
        held_va_next  = in_item.virt_addr;
        stage_next    = STG_L1;
      end
    end else begin
      unique case (stage)
        STG_L1: begin
          wr.entry.op = OP_L1;
          stage_next  = (in_item.read_word[1:0] == DESC_TABLE) ? STG_L2 : STG_IDLE;
        end
        STG_L2: begin
          wr.entry.op = OP_L2;
          stage_next  = STG_IDLE;
        end
        default: begin
          // A descriptor while idle is out of order and leaves the state alone.
          wr.entry.op = OP_ORDER;
          stage_next  = STG_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage   <= STG_IDLE;
      held_va <= '0;
    end else if (accept) begin
      stage   <= stage_next;
      held_va <= held_va_next;
    end
  end

endmodule

/* rtl/sdtw_queue.sv */
// ----------------------------------------------------------------------------
// Walker operation queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sdtw_queue #(
  parameter int unsigned QUEUE_DEPTH = sdtw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  sdtw_pkg::q_port_t wr,
  output logic              full,
  input  logic              pop,
  output sdtw_pkg::q_port_t head,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
  import sdtw_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == CntW'(QUEUE_DEPTH));
  assign do_push    = wr.valid && !full;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

/* rtl/sdtw_back.sv */
// ----------------------------------------------------------------------------
// Walker back end
// Builds read requests and translations and holds them in the output register.
// ----------------------------------------------------------------------------
module sdtw_back (
  input  logic                clk,
  input  logic                rst,
  input  sdtw_pkg::q_port_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sdtw_pkg::out_item_t out_item
);
  import sdtw_pkg::*;

  out_item_t res;
  logic [31:0] va;
  logic [31:0] d;

  assign va  = head.entry.va;
  assign d   = head.entry.word;
  assign pop = head.valid && (!out_valid || out_ready);

  always_comb begin
    res.kind         = KIND_DONE;
    res.read_address = '0;
    res.phys_addr    = '0;
    res.page_kind    = PK_SECTION;
    res.status       = ST_OK;
    unique case (head.entry.op)
      OP_START: begin
        res.kind         = KIND_REQ;
        res.read_address = {d[31:14], va[31:20], 2'b00};
      end
      OP_ORDER: begin
        res.status = ST_ORDER;
      end
      OP_L1: begin
        case (d[1:0])
          DESC_FAULT: res.status = ST_L1_FAULT;
          DESC_TABLE: begin
            res.kind         = KIND_REQ;
            res.read_address = {d[31:10], va[19:12], 2'b00};
          end
          DESC_SECTION: begin
            if (d[SUPER_BIT]) begin
              res.phys_addr = {d[8:5], d[23:20], d[31:24], va[23:0]};
              res.page_kind = PK_SUPERSECTION;
            end else begin
              res.phys_addr = {8'h00, d[31:20], va[19:0]};
            end
          end
          default: res.status = ST_RESERVED;
        endcase
      end
      default: begin
        case (d[1:0])
          L2_FAULT: res.status = ST_L2_FAULT;
          L2_LARGE: begin
            res.phys_addr = {8'h00, d[31:16], va[15:0]};
            res.page_kind = PK_LARGE;
          end
          default: begin
            res.phys_addr = {8'h00, d[31:12], va[11:0]};
            res.page_kind = PK_SMALL;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= res;
    end
  end

endmodule

/* rtl/short_descriptor_table_walker_core.sv */
// ----------------------------------------------------------------------------
// Short-descriptor table walker core
// Two-level 32-bit short-descriptor page-table walk with two table bases.
// ----------------------------------------------------------------------------
// Usage: the in_ch channel carries walk transactions. A start transaction
// (action 0) gives a virtual address and selects table base 0 or 1; the block
// answers with a read request for the level-1 descriptor. The caller fetches
// that word and sends it back as a descriptor transaction (action 1). A table
// descriptor produces a second read request for the level-2 descriptor; a
// section, supersection, large or small page produces a finished walk with a
// 40-bit physical address, page kind and status. Every input transaction
// yields exactly one out_ch transaction. Starts during a walk and descriptors
// while idle are answered with an out-of-order status and change nothing.
// An accepted transaction is classified into the operation queue, then moves
// to the output register. Throughput is one transaction per cycle while out_ch
// is ready; it is set by the output register, which is refilled in the cycle
// it is drained. When out_ch stalls, the queue absorbs up to QUEUE_DEPTH
// transactions and then in_ch.ready drops. Reset empties the queue, clears the
// output valid, returns the walk to idle and clears both table base registers.
// Table bases are written through cfg_write_en / cfg_index / cfg_write_data;
// the caller must write them only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "short_descriptor_table_walker_core_macros.svh"

module short_descriptor_table_walker_core #(
  parameter int unsigned QUEUE_DEPTH = sdtw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  sdtw_in_if.sink     in_ch,
  sdtw_out_if.source  out_ch,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_write_data
);
  import sdtw_pkg::*;

  // Translation table base registers.
  logic [31:0] ttb0;
  logic [31:0] ttb1;

  // Front end to queue, and queue to back end.
  q_port_t wr;
  q_port_t head;
  logic    q_full;
  logic    pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttb0 <= '0;
      ttb1 <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_TTB0: ttb0 <= cfg_write_data;
        CFG_TTB1: ttb1 <= cfg_write_data;
        default:  ttb0 <= ttb0;
      endcase
    end
  end

  // The front end takes a new transaction whenever the queue has room; the walk
  // state advances at acceptance so back-to-back transactions see it updated.
  assign in_ch.ready = !q_full;

  sdtw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_ch.payload),
    .ttb0     (ttb0),
    .ttb1     (ttb1),
    .wr       (wr)
  );

  sdtw_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .full  (q_full),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  // The back end turns each queued operation into a result and holds it in
  // the output register until out_ch takes it.
  sdtw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
  );

  // The queue never holds more operations than it has slots.
  `SDTW_ASSERT_SAME(a_queue_bound, 1'b1, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))

  // A level-2 descriptor always finishes the walk.
  `SDTW_ASSERT_NEXT(a_l2_finishes, pop && head.entry.op == OP_L2, out_ch.payload.kind == KIND_DONE)

  // A start that was accepted always turns into a read request.
  `SDTW_ASSERT_NEXT(a_start_requests, pop && head.entry.op == OP_START, out_ch.payload.kind == KIND_REQ)

  // Any failing walk reports no physical address.
  `SDTW_ASSERT_SAME(a_fault_zero_pa, out_ch.valid && out_ch.payload.status != ST_OK, out_ch.payload.phys_addr == '0)

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Short-descriptor table walker core testbench
// Sends start and descriptor transactions into the walker under bursty input
// traffic and output back-pressure. A predictor of the two-level walk holds its
// own copy of the table bases and the walk state, and it checks every result
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdtw_pkg::*;

  // Walk progress as the predictor tracks it.
  typedef enum logic [1:0] {
    STAGE_IDLE    = 2'd0,
    STAGE_WAIT_L1 = 2'd1,
    STAGE_WAIT_L2 = 2'd2
  } walk_stage_t;

  // Generous: about 1800 transactions, each of which could wait out a sender
  // gap, a long receiver stall and the block's pipeline, with room to spare.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles to let pass once nothing is expected; the core holds a queue and an output register.
  localparam int unsigned DRAIN_CYCLES = 4;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic        cfg_index;
  logic [31:0] cfg_write_data;

  sdtw_in_if  in_ch ();
  sdtw_out_if out_ch ();

  short_descriptor_table_walker_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_write_data (cfg_write_data)
  );

  // Transactions waiting to be sent, and walk results waiting to arrive.
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  // Predictor state: its own copy of the table bases and of the walk.
  logic [31:0] ttb0_model;
  logic [31:0] ttb1_model;
  walk_stage_t stage_model;
  logic [31:0] held_va_model;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned read_requests;
  int unsigned page_counts[4];
  int unsigned fault_count;
  int unsigned order_count;

  // Sender burst shaping and receiver stall pattern.
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The timeout is the only way besides the final check that the run can end.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Predicts the result of one accepted transaction and advances the walk.
  // A start while a walk is pending, or a descriptor while idle, is answered
  // as out of order and leaves the walk exactly as it was.
  function automatic out_item_t predict_walk_result(input in_item_t item);
    out_item_t   res;
    logic [31:0] base;
    logic [31:0] d;
    logic [31:0] va;

    res  = '0;
    d    = item.read_word;
    va   = held_va_model;
    base = item.base_select ? ttb1_model : ttb0_model;
    res.kind = KIND_DONE;

    if (item.action == ACT_START) begin
      if (stage_model != STAGE_IDLE) begin
        res.status = ST_ORDER;
      end else begin
        // Level-1 index is va[31:20], one word per entry.
        held_va_model    = item.virt_addr;
        stage_model      = STAGE_WAIT_L1;
        res.kind         = KIND_REQ;
        res.read_address = {base[31:14], item.virt_addr[31:20], 2'b00};
      end
    end else if (stage_model == STAGE_WAIT_L1) begin
      stage_model = STAGE_IDLE;
      case (d[1:0])
        DESC_FAULT: begin
          res.status = ST_L1_FAULT;
        end
        DESC_TABLE: begin
          // Coarse table: the level-2 index is va[19:12].
          stage_model      = STAGE_WAIT_L2;
          res.kind         = KIND_REQ;
          res.read_address = {d[31:10], va[19:12], 2'b00};
        end
        DESC_SECTION: begin
          if (d[SUPER_BIT]) begin
            // Supersection: extended address bits come from d[8:5] and d[23:20].
            res.phys_addr = {d[8:5], d[23:20], d[31:24], va[23:0]};
            res.page_kind = PK_SUPERSECTION;
          end else begin
            res.phys_addr = {8'h00, d[31:20], va[19:0]};
            res.page_kind = PK_SECTION;
          end
        end
        default: begin
          res.status = ST_RESERVED;
        end
      endcase
    end else if (stage_model == STAGE_WAIT_L2) begin
      stage_model = STAGE_IDLE;
      case (d[1:0])
        L2_FAULT: begin
          res.status = ST_L2_FAULT;
        end
        L2_LARGE: begin
          res.phys_addr = {8'h00, d[31:16], va[15:0]};
          res.page_kind = PK_LARGE;
        end
        default: begin
          // Both remaining type codes are small pages.
          res.phys_addr = {8'h00, d[31:12], va[11:0]};
          res.page_kind = PK_SMALL;
        end
      endcase
    end else begin
      res.status = ST_ORDER;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [39:0] want,
                             input logic [39:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, name, want, got);
    end
  endtask

  // Driver. The sender alternates bursts and gaps; a transaction that is not
  // accepted keeps valid high until the walker takes it. The valid is written
  // once per edge, so it never drops and rises within one time step.
  always @(posedge clk) begin : sender
    logic holding;
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      holding = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_walk_result(in_ch.payload));
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          in_ch.payload <= pending_items.pop_front();
          holding = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 7) == 0) begin
            // Now and then a long stretch with no idle cycles at all.
            burst_left = $urandom_range(20, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
      in_ch.valid <= holding;
    end
  end

  // Monitor. Results are compared against the oldest prediction; the ready
  // pattern switches between full rate, random, periodic and heavy stalls.
  always @(posedge clk) begin : receiver
    out_item_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      stall_mode = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual 0x%0h",
                   $realtime, out_ch.payload);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          check_field("kind", 40'(want.kind), 40'(out_ch.payload.kind));
          check_field("read_address", 40'(want.read_address),
                      40'(out_ch.payload.read_address));
          check_field("phys_addr", want.phys_addr, out_ch.payload.phys_addr);
          check_field("page_kind", 40'(want.page_kind), 40'(out_ch.payload.page_kind));
          check_field("status", 40'(want.status), 40'(out_ch.payload.status));
          if (want.kind == KIND_REQ) begin
            read_requests++;
          end else if (want.status == ST_OK) begin
            page_counts[want.page_kind]++;
          end else if (want.status == ST_ORDER) begin
            order_count++;
          end else begin
            fault_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(32, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= cycle_count[1];
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // A start transaction; the descriptor field carries noise the walker ignores.
  task automatic push_start(input logic [31:0] va, input logic sel);
    in_item_t item;
    item.action      = ACT_START;
    item.virt_addr   = va;
    item.base_select = sel;
    item.read_word   = $urandom();
    pending_items.push_back(item);
  endtask

  // A descriptor transaction; address and select fields carry noise.
  task automatic push_desc(input logic [31:0] word);
    in_item_t item;
    item.action      = ACT_DESC;
    item.virt_addr   = $urandom();
    item.base_select = 1'($urandom_range(0, 1));
    item.read_word   = word;
    pending_items.push_back(item);
  endtask

  // Random descriptor with its type code forced; all other bits are random,
  // so the supersection bit is set about half the time.
  function automatic logic [31:0] typed_desc(input logic [1:0] code);
    logic [31:0] word;
    word = $urandom();
    word[1:0] = code;
    return word;
  endfunction

  // Mostly complete walks with random content; the rest are lone descriptors
  // and extra starts that break the expected order.
  task automatic add_random_walks(input int unsigned count);
    int unsigned first;
    int unsigned roll;
    logic [1:0]  l1_code;
    first = pending_items.size();
    while (pending_items.size() - first < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        push_start($urandom(), 1'($urandom_range(0, 1)));
        roll = $urandom_range(0, 99);
        if (roll < 10) l1_code = DESC_FAULT;
        else if (roll < 55) l1_code = DESC_TABLE;
        else if (roll < 90) l1_code = DESC_SECTION;
        else l1_code = DESC_RESERVED;
        push_desc(typed_desc(l1_code));
        if (l1_code == DESC_TABLE) begin
          push_desc(typed_desc(2'($urandom_range(0, 3))));
        end
      end else if (roll < 93) begin
        push_desc($urandom());
      end else begin
        push_start($urandom(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Waits until every sent transaction has its result back, then lets the
  // pipeline settle so a register write never races a transaction. The check
  // runs on the falling edge, once the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_base(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_index      <= idx;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == CFG_TTB0) ttb0_model = value;
    else ttb1_model = value;
  endtask

  task automatic set_table_bases(input logic [31:0] base0, input logic [31:0] base1);
    wait_drained();
    write_table_base(CFG_TTB0, base0);
    write_table_base(CFG_TTB1, base1);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_index      = CFG_TTB0;
    cfg_write_data = '0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cycle_count    = 0;
    error_count    = 0;
    results_seen   = 0;
    read_requests  = 0;
    fault_count    = 0;
    order_count    = 0;
    page_counts    = '{default: 0};
    ttb0_model     = '0;
    ttb1_model     = '0;
    stage_model    = STAGE_IDLE;
    held_va_model  = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every descriptor type at both levels, the supersection
    // layout, and both kinds of out-of-order transaction.
    set_table_bases(32'hFFFF_FFFF, 32'h0000_0000);
    push_start(32'hFFFF_FFFF, 1'b0);
    push_desc(32'hFFF0_0002);          // section, all-ones offset
    push_start(32'h0000_0000, 1'b1);
    push_desc(32'hFFFF_FFFE);          // supersection, every descriptor address bit set
    push_start(32'h1234_5678, 1'b0);
    push_desc(32'hFFFF_FC01);          // page table
    push_desc(32'hFFFF_0001);          // large page
    push_start(32'hFFFF_FFFF, 1'b1);
    push_desc(32'h0000_0001);          // page table at address zero
    push_desc(32'hFFFF_F002);          // small page
    push_start(32'hA5A5_A5A5, 1'b0);
    push_desc(32'h5A5A_5A01);
    push_desc(32'hFFFF_FFFF);          // small page with the other type code
    push_start(32'h0010_0000, 1'b1);
    push_desc(32'h0000_0001);
    push_desc(32'hFFFF_FFFC);          // level-2 fault
    push_start(32'h0000_0000, 1'b0);
    push_desc(32'hFFFF_FFFC);          // level-1 fault
    push_start(32'hFFF0_0000, 1'b1);
    push_desc(32'hFFFF_FFFF);          // reserved level-1 descriptor
    push_desc(32'hFFFF_FFFE);          // descriptor while idle
    push_start(32'h8765_4321, 1'b1);
    push_start(32'hFFFF_FFFF, 1'b0);   // start while waiting for level 1
    push_desc(32'h0003_C001);
    push_start(32'h0000_0000, 1'b1);   // start while waiting for level 2
    push_desc(32'h0000_0002);

    // Random part over several base settings, extremes among them.
    set_table_bases(32'h0000_0000, 32'hFFFF_FFFF);
    add_random_walks(290);
    set_table_bases($urandom(), $urandom());
    add_random_walks(290);
    set_table_bases(32'h0000_3FFF, 32'hFFFF_C000);
    add_random_walks(290);
    set_table_bases($urandom(), $urandom());
    add_random_walks(290);
    set_table_bases(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_random_walks(290);
    set_table_bases($urandom(), 32'h0000_0000);
    add_random_walks(290);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Checked %0d walk results: %0d descriptor reads, %0d sections, %0d supersections,",
             results_seen, read_requests, page_counts[PK_SECTION],
             page_counts[PK_SUPERSECTION]);
    $display("%0d large pages, %0d small pages, %0d faults, %0d out of order, %0d mismatches",
             page_counts[PK_LARGE], page_counts[PK_SMALL], fault_count, order_count,
             error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
